// ===== rtl/fsl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsl_pkg
// Shared constants, codes and controller/datapath interface types for the
// sublist search block.
// ----------------------------------------------------------------------------
package fsl_pkg;

    // fixed field widths
    localparam int VALUE_W   = 32;
    localparam int INDEX_W   = 6;
    localparam int LEN_REG_W = 7;
    localparam int POS_W     = 16;

    // configuration port
    localparam int APB_DW  = 32;
    localparam int PADDR_W = 3;
    localparam logic REG_PATTERN_LEN = 1'b0;

    // item kinds
    localparam logic ACT_PATTERN = 1'b0;
    localparam logic ACT_TEXT    = 1'b1;

    // parameter defaults
    localparam int          DEF_PATTERN_MAX = 64;
    localparam int unsigned DEF_TEXT_MAX    = 65535;
    localparam int          DEF_DATA_WIDTH  = 32;

    typedef struct packed {
        logic pat_write;  // store a pattern word
        logic text_push;  // append a text word to the window
        logic eval;       // decide on a window check, load scan pointers
        logic step;       // advance the scan by one word
        logic hit;        // record a match at the current alignment
        logic load_out;   // load result word, clear text state
    } fsl_cmd_t;

    typedef struct packed {
        logic last;       // pending text word closes the sequence
        logic need_cmp;   // window must be checked against the pattern
        logic issue_left; // scan reads still to issue
        logic dvalid;     // read data of the scan is valid
        logic word_eq;    // pattern and text words agree
    } fsl_stat_t;

endpackage
`default_nettype wire

// ===== rtl/fsl_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fsl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/fsl_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsl_dpath
// Pattern and text RAMs, text counters, match record, scan pointers and the
// result word register.
// ----------------------------------------------------------------------------
module fsl_dpath import fsl_pkg::*; #(
    parameter int          PATTERN_MAX = DEF_PATTERN_MAX,
    parameter int unsigned TEXT_MAX    = DEF_TEXT_MAX,
    parameter int          DATA_WIDTH  = DEF_DATA_WIDTH
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [INDEX_W-1:0]   index,
    input  wire logic [VALUE_W-1:0]   value,
    input  wire logic                 last,
    input  wire logic [LEN_REG_W-1:0] pattern_len,
    input  wire fsl_cmd_t             cmd,
    output fsl_stat_t                 stat,
    output logic                      found,
    output logic [POS_W-1:0]          position
);

    localparam int AW    = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int LEN_W = $clog2(PATTERN_MAX + 1);
    localparam int CNT_W = $clog2(64'(TEXT_MAX) + 64'd1);
    localparam int CW2   = (CNT_W > LEN_W) ? CNT_W : LEN_W;
    localparam int SW    = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
        return (a == AW'(PATTERN_MAX - 1)) ? '0 : a + 1'b1;
    endfunction

    logic [AW-1:0]    wptr_reg,   wptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             seen_reg,   seen_next;
    logic [CNT_W-1:0] start_reg,  start_next;
    logic             last_reg,   last_next;
    logic [AW-1:0]    pa_reg,     pa_next;
    logic [AW-1:0]    ta_reg,     ta_next;
    logic [LEN_W-1:0] rem_reg,    rem_next;
    logic             dvalid_reg, dvalid_next;
    logic             found_reg;
    logic [POS_W-1:0] position_reg;

    logic [LEN_W-1:0] plen;
    logic [AW-1:0]    offs;
    logic [AW-1:0]    base;
    logic [AW-1:0]    wptr_inc;
    logic [AW-1:0]    pat_waddr;
    logic             idx_ok;
    logic [SW-1:0]    pat_rdata;
    logic [SW-1:0]    txt_rdata;
    logic             empty_hit;
    logic [CW2-1:0]   hit_start;
    logic [CNT_W+POS_W-1:0] pos_ext;

    // pattern length clipped to the store depth
    assign plen = (32'(pattern_len) > PATTERN_MAX) ? LEN_W'(PATTERN_MAX)
                                                   : LEN_W'(pattern_len);

    // oldest word of the window: newest minus (plen - 1), modulo depth
    assign offs = AW'(plen - 1'b1);
    assign base = (wptr_reg >= offs) ? wptr_reg - offs
                : AW'((AW+1)'(wptr_reg) + (AW+1)'(PATTERN_MAX) - (AW+1)'(offs));

    assign wptr_inc  = wrap_inc(wptr_reg);
    assign idx_ok    = (32'(index) < PATTERN_MAX);
    assign pat_waddr = AW'(32'(index));
    assign empty_hit = !seen_reg && (plen == '0);
    assign hit_start = CW2'(count_reg) - CW2'(plen);

    fsl_ram #(
        .WIDTH (SW),
        .DEPTH (PATTERN_MAX)
    ) u_pat_ram (
        .clk   (clk),
        .we    (cmd.pat_write && idx_ok),
        .waddr (pat_waddr),
        .wdata (value[SW-1:0]),
        .raddr (pa_reg),
        .rdata (pat_rdata)
    );

    // text window kept as a circular buffer, newest word at wptr_reg
    fsl_ram #(
        .WIDTH (SW),
        .DEPTH (PATTERN_MAX)
    ) u_txt_ram (
        .clk   (clk),
        .we    (cmd.text_push),
        .waddr (wptr_inc),
        .wdata (value[SW-1:0]),
        .raddr (ta_reg),
        .rdata (txt_rdata)
    );

    always_comb
    begin
        stat.last       = last_reg;
        stat.need_cmp   = !seen_reg && (plen != '0) && (CW2'(count_reg) >= CW2'(plen));
        stat.issue_left = (rem_reg != '0);
        stat.dvalid     = dvalid_reg;
        stat.word_eq    = (pat_rdata == txt_rdata);
    end

    always_comb
    begin
        wptr_next   = wptr_reg;
        count_next  = count_reg;
        seen_next   = seen_reg;
        start_next  = start_reg;
        last_next   = last_reg;
        pa_next     = pa_reg;
        ta_next     = ta_reg;
        rem_next    = rem_reg;
        dvalid_next = dvalid_reg;

        if (cmd.text_push)
        begin
            wptr_next  = wptr_inc;
            count_next = (count_reg == CNT_W'(TEXT_MAX)) ? count_reg : count_reg + 1'b1;
            last_next  = last;
        end

        if (cmd.eval)
        begin
            if (empty_hit)
            begin
                seen_next  = 1'b1;
                start_next = '0;
            end
            pa_next     = '0;
            ta_next     = base;
            rem_next    = plen;
            dvalid_next = 1'b0;
        end

        if (cmd.step)
        begin
            dvalid_next = (rem_reg != '0);
            if (rem_reg != '0)
            begin
                pa_next  = pa_reg + 1'b1;
                ta_next  = wrap_inc(ta_reg);
                rem_next = rem_reg - 1'b1;
            end
        end

        if (cmd.hit)
        begin
            seen_next  = 1'b1;
            start_next = CNT_W'(hit_start);
        end

        if (cmd.load_out)
        begin
            count_next = '0;
            seen_next  = 1'b0;
            start_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg   <= AW'(PATTERN_MAX - 1);
            count_reg  <= '0;
            seen_reg   <= 1'b0;
            start_reg  <= '0;
            last_reg   <= 1'b0;
            pa_reg     <= '0;
            ta_reg     <= '0;
            rem_reg    <= '0;
            dvalid_reg <= 1'b0;
        end
        else
        begin
            wptr_reg   <= wptr_next;
            count_reg  <= count_next;
            seen_reg   <= seen_next;
            start_reg  <= start_next;
            last_reg   <= last_next;
            pa_reg     <= pa_next;
            ta_reg     <= ta_next;
            rem_reg    <= rem_next;
            dvalid_reg <= dvalid_next;
        end
    end

    // position carries the low bits of the start or of the text length
    assign pos_ext = (CNT_W+POS_W)'(seen_reg ? start_reg : count_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            found_reg    <= seen_reg;
            position_reg <= pos_ext[POS_W-1:0];
        end
    end

    assign found    = found_reg;
    assign position = position_reg;

endmodule
`default_nettype wire

// ===== rtl/fsl_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fsl_ctrl
// Sequencer: takes words, runs the window scan and hands off the result word.
// ----------------------------------------------------------------------------
module fsl_ctrl import fsl_pkg::*; (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    input  wire logic      action,
    input  wire logic      out_stall,
    input  wire fsl_stat_t stat,
    output logic           in_stall,
    output logic           out_valid,
    output fsl_cmd_t       cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EVAL   = 2'd1;
    localparam logic [1:0] S_CMP    = 2'd2;
    localparam logic [1:0] S_RESULT = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_room;
    logic [1:0] after_text;

    assign out_room   = !out_valid_reg || !out_stall;
    assign after_text = stat.last ? S_RESULT : S_IDLE;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (action == ACT_TEXT)
                    begin
                        cmd.text_push = 1'b1;
                        state_next    = S_EVAL;
                    end
                    else
                    begin
                        cmd.pat_write = 1'b1;
                    end
                end
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = stat.need_cmp ? S_CMP : after_text;
            end
            S_CMP:
            begin
                cmd.step = 1'b1;
                // stop at the first mismatch, or after the oldest-to-newest sweep
                if (stat.dvalid && !stat.word_eq)
                begin
                    state_next = after_text;
                end
                else if (stat.dvalid && !stat.issue_left)
                begin
                    cmd.hit    = 1'b1;
                    state_next = after_text;
                end
            end
            S_RESULT:
            begin
                if (out_room)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

// ===== rtl/first_sublist_match.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// first_sublist_match
// Leftmost occurrence of a stored pattern in a streamed text.
// ----------------------------------------------------------------------------
// Write pattern_len over the APB port, load the pattern words by index, then
// stream text words; the text word marked last returns one result word
// (found, position), where position is the text length when nothing
// matched. A pattern word is stored without stalling the input. Each text
// word is stored and then followed by the window decision. The window is
// checked only while no match has been seen, the pattern is not empty and
// at least pattern_len words have arrived; the check runs one word per
// cycle through the single read port of the pattern and text RAMs, leaving
// at the first mismatch. The last word then loads the result register, and
// waits there while a previous result word is still held by out_stall.
// Input is taken while a result word waits to be read.
// ----------------------------------------------------------------------------
module first_sublist_match import fsl_pkg::*; #(
    parameter int          PATTERN_MAX = DEF_PATTERN_MAX,
    parameter int unsigned TEXT_MAX    = DEF_TEXT_MAX,
    parameter int          DATA_WIDTH  = DEF_DATA_WIDTH
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // input words
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               action,
    input  wire logic [INDEX_W-1:0] index,
    input  wire logic [VALUE_W-1:0] value,
    input  wire logic               last,
    // result words
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic                    found,
    output logic [POS_W-1:0]        position,
    // configuration
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]       prdata,
    output logic                    pready
);

    logic [LEN_REG_W-1:0] pattern_len_reg, pattern_len_next;
    logic                 reg_sel;
    fsl_cmd_t             cmd;
    fsl_stat_t            stat;

    assign pready  = 1'b1;
    assign reg_sel = paddr[PADDR_W-1];

    always_comb
    begin
        pattern_len_next = pattern_len_reg;
        if (psel && penable && pwrite && (reg_sel == REG_PATTERN_LEN))
        begin
            pattern_len_next = pwdata[LEN_REG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_len_reg <= '0;
        end
        else
        begin
            pattern_len_reg <= pattern_len_next;
        end
    end

    assign prdata = (reg_sel == REG_PATTERN_LEN) ? APB_DW'(pattern_len_reg) : '0;

    fsl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .action    (action),
        .out_stall (out_stall),
        .stat      (stat),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    fsl_dpath #(
        .PATTERN_MAX (PATTERN_MAX),
        .TEXT_MAX    (TEXT_MAX),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .index       (index),
        .value       (value),
        .last        (last),
        .pattern_len (pattern_len_reg),
        .cmd         (cmd),
        .stat        (stat),
        .found       (found),
        .position    (position)
    );

    // a text word is always followed by the window decision
    a_text_eval: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && action == ACT_TEXT) |=> cmd.eval)
        else $error("text word not followed by window decision");

    // a new result word only comes from a result load
    a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.load_out))
        else $error("result word raised without a load");

    // no input is taken while a result is loaded
    a_load_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> in_stall)
        else $error("input taken during result load");

    // a match is only recorded on valid, equal scan data
    a_hit_on_data: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.hit |-> (stat.dvalid && stat.word_eq && !stat.issue_left))
        else $error("match recorded without complete scan");

endmodule
`default_nettype wire

// ===== verif/first_sublist_match_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_sublist_match_checker
// Scoreboard for the sublist search block.
// ----------------------------------------------------------------------------
// Follows the pattern_len register through the APB port. For every accepted
// input word it updates its own pattern store, text window, length and match
// state, and queues one expected result for each word that closes a text.
// Each accepted result word is checked field by field against the oldest
// queued expectation.
// ----------------------------------------------------------------------------
module first_sublist_match_checker import fsl_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic               action,
    input  logic [INDEX_W-1:0] index,
    input  logic [VALUE_W-1:0] value,
    input  logic               last,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic               found,
    input  logic [POS_W-1:0]   position,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [APB_DW-1:0]  pwdata,
    input  logic               pready,
    output int                 errors,
    output int                 pending,
    output int                 checked
);

    localparam int MAX_REPORTS = 10;
    localparam logic [PADDR_W-1:0] LEN_ADDR = {REG_PATTERN_LEN, 2'b00};

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } search_result_t;

    logic [VALUE_W-1:0]   pat_mem [DEF_PATTERN_MAX];
    logic [VALUE_W-1:0]   recent  [DEF_PATTERN_MAX];  // entry 0 is the newest text word
    int unsigned          text_len;
    logic                 hit_seen;
    int unsigned          hit_at;
    logic [LEN_REG_W-1:0] len_reg;
    search_result_t       results_q [$];
    int                   mism;
    int                   n_checked;

    task automatic clear_text();
        int k;
        for (k = 0; k < DEF_PATTERN_MAX; k++)
            recent[k] = '0;
        text_len = 0;
        hit_seen = 1'b0;
        hit_at   = 0;
    endtask

    // pattern word k lines up with the text word n-1-k places back
    function automatic bit window_hits(int unsigned n);
        int unsigned k;
        for (k = 0; k < n; k++)
            if (pat_mem[k] != recent[n - 1 - k])
                return 1'b0;
        return 1'b1;
    endfunction

    task automatic absorb_word(input logic act, input logic [INDEX_W-1:0] idx,
                               input logic [VALUE_W-1:0] val, input logic lst);
        int unsigned    n;
        int             k;
        search_result_t r;
        n = (len_reg > DEF_PATTERN_MAX) ? DEF_PATTERN_MAX : len_reg;
        if (act == ACT_PATTERN)
        begin
            pat_mem[idx] = val;
            return;
        end
        for (k = DEF_PATTERN_MAX - 1; k > 0; k--)
            recent[k] = recent[k - 1];
        recent[0] = val;
        if (text_len < DEF_TEXT_MAX)
            text_len++;
        if (!hit_seen)
        begin
            if (n == 0)
            begin
                hit_seen = 1'b1;
                hit_at   = 0;
            end
            else if (text_len >= n && window_hits(n))
            begin
                hit_seen = 1'b1;
                hit_at   = text_len - n;
            end
        end
        if (lst)
        begin
            r.found    = hit_seen;
            r.position = hit_seen ? POS_W'(hit_at) : POS_W'(text_len);
            results_q  = {results_q, r};
            clear_text();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        search_result_t want;
        int k;
        if (!rst_n)
        begin
            for (k = 0; k < DEF_PATTERN_MAX; k++)
                pat_mem[k] = '0;
            clear_text();
            len_reg = '0;
            results_q.delete();
            mism      = 0;
            n_checked = 0;
            errors  <= 0;
            pending <= 0;
            checked <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == LEN_ADDR)
                len_reg = pwdata[LEN_REG_W-1:0];
            if (out_valid && !out_stall)
            begin
                if (results_q.size() == 0)
                begin
                    mism++;
                    if (mism <= MAX_REPORTS)
                        $display("%0t: result word with nothing pending: found=%0b position=%0d",
                                 $realtime, found, position);
                end
                else
                begin
                    want = results_q.pop_front();
                    n_checked++;
                    if (found !== want.found || position !== want.position)
                    begin
                        mism++;
                        if (mism <= MAX_REPORTS)
                            $display({"%0t: result %0d: expected found=%0b position=%0d, ",
                                      "got found=%0b position=%0d"}, $realtime, n_checked,
                                     want.found, want.position, found, position);
                    end
                end
            end
            if (in_valid && !in_stall)
                absorb_word(action, index, value, last);
            errors  <= mism;
            pending <= results_q.size();
            checked <= n_checked;
        end
    end

endmodule

// ===== verif/first_sublist_match_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_sublist_match_tb
// Stimulus and verdict for the sublist search block.
// ----------------------------------------------------------------------------
// Directed corner cases first (empty pattern, restart after a partial match,
// text shorter than the pattern, extreme words and indexes), then a long
// hold-off on the result side and random pattern/text phases over many
// pattern lengths. The sender works in bursts and the receiver stalls on its
// own pattern; checking is done by first_sublist_match_checker.
// ----------------------------------------------------------------------------
module first_sublist_match_tb import fsl_pkg::*; ();

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 6;
    localparam int RANDOM_WORDS  = 1200;
    localparam int SETTLE_CYCLES = 100;
    localparam int HOLD_CYCLES   = 400;
    localparam int IDLE_LIMIT    = 5000;
    localparam int TXT_BUF_LEN   = 2 * DEF_PATTERN_MAX + 8;
    localparam logic [PADDR_W-1:0] LEN_ADDR = {REG_PATTERN_LEN, 2'b00};

    typedef enum int {FLOW, LIGHT, HEAVY, CHOKE} stall_mode_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               action;
    logic [INDEX_W-1:0] index;
    logic [VALUE_W-1:0] value;
    logic               last;
    logic               out_valid;
    logic               out_stall;
    logic               found;
    logic [POS_W-1:0]   position;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [APB_DW-1:0]  pwdata;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    int errors;
    int pending;
    int checked;
    int words_sent  = 0;
    int burst_left  = 0;
    int hold_req    = 0;
    int idle_cycles = 0;
    bit offering    = 1'b0;
    bit rush        = 1'b0;

    first_sublist_match dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .index     (index),
        .value     (value),
        .last      (last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .found     (found),
        .position  (position),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    first_sublist_match_checker chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .index     (index),
        .value     (value),
        .last      (last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .found     (found),
        .position  (position),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .pready    (pready),
        .errors    (errors),
        .pending   (pending),
        .checked   (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // watchdog: ends the run after too long without any accepted word
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("first_sublist_match_tb: done, errors");
            $finish;
        end
    end

    // result side: random stall modes, plus a long hold-off on request
    initial
    begin
        stall_mode_t mode;
        int          span;
        int          hold_seen;
        mode      = FLOW;
        span      = 0;
        hold_seen = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (span == 0)
            begin
                mode = stall_mode_t'($urandom_range(0, 3));
                span = $urandom_range(8, 80);
            end
            span--;
            case (mode)
                FLOW:    out_stall <= 1'b0;
                LIGHT:   out_stall <= ($urandom_range(0, 7) == 0);
                HEAVY:   out_stall <= ($urandom_range(0, 1) == 0);
                default: out_stall <= ($urandom_range(0, 15) != 0);
            endcase
        end
    end

    task automatic send_word(input logic act, input logic [INDEX_W-1:0] idx,
                             input logic [VALUE_W-1:0] val, input logic lst);
        int gap;
        in_valid <= 1'b1;
        offering = 1'b1;
        action   <= act;
        index    <= idx;
        value    <= val;
        last     <= lst;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        words_sent++;
        if (!rush)
        begin
            if (burst_left > 0)
                burst_left--;
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 30);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0)
                begin
                    in_valid <= 1'b0;
                    offering = 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    endtask

    // last is don't-care on pattern words, index on text words
    task automatic put_pattern(input int i, input logic [VALUE_W-1:0] val);
        send_word(ACT_PATTERN, INDEX_W'(i), val, 1'($urandom_range(0, 1)));
    endtask

    task automatic put_text(input logic [VALUE_W-1:0] val, input logic lst);
        send_word(ACT_TEXT, INDEX_W'($urandom), val, lst);
    endtask

    // drain results, then give a trailing scan time to finish
    task automatic settle();
        if (offering)
        begin
            in_valid <= 1'b0;
            offering = 1'b0;
        end
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_len(input logic [LEN_REG_W-1:0] len);
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LEN_ADDR;
        pwdata  <= APB_DW'(len);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic directed_cases();
        // empty pattern hits at 0
        write_len(0);
        put_text(32'h8000_0000, 1'b0);
        put_text(32'h7FFF_FFFF, 1'b1);
        // pattern 1 1 2: text 1 1 1 2 needs a restart after the partial match
        write_len(3);
        send_word(ACT_PATTERN, 0, 32'd1, 1'b0);
        send_word(ACT_PATTERN, 1, 32'd1, 1'b1);
        send_word(ACT_PATTERN, 2, 32'd2, 1'b0);
        put_text(32'd1, 1'b0);
        put_text(32'd1, 1'b0);
        put_text(32'd1, 1'b0);
        put_text(32'd2, 1'b1);
        // text shorter than the pattern
        put_text(32'd1, 1'b0);
        put_text(32'd1, 1'b1);
        send_word(ACT_PATTERN, '1, 32'h8000_0000, 1'b1);
        write_len(2);
        send_word(ACT_PATTERN, 0, 32'hFFFF_FFFF, 1'b0);
        send_word(ACT_PATTERN, 1, 32'h0000_0000, 1'b0);
        put_text(32'h0000_0000, 1'b0);
        put_text(32'hFFFF_FFFF, 1'b0);
        put_text(32'h0000_0000, 1'b1);
    endtask

    // back-to-back texts while the result side holds off
    task automatic pressure_case();
        logic [VALUE_W-1:0] a;
        logic [VALUE_W-1:0] b;
        int i;
        a = $urandom;
        b = ~a;
        write_len(2);
        put_pattern(0, a);
        put_pattern(1, b);
        rush = 1'b1;
        hold_req <= hold_req + 1;
        for (i = 0; i < 8; i++)
        begin
            put_text($urandom, 1'b0);
            put_text(a, 1'b0);
            put_text(b, 1'b1);
        end
        rush = 1'b0;
    endtask

    task automatic random_phase();
        int unsigned          pick;
        int unsigned          eff;
        int unsigned          nsym;
        int unsigned          nseq;
        int unsigned          tlen;
        int unsigned          at;
        int unsigned          s;
        int unsigned          i;
        int unsigned          j;
        logic [LEN_REG_W-1:0] len;
        logic [VALUE_W-1:0]   sym [4];
        logic [VALUE_W-1:0]   pat [DEF_PATTERN_MAX];
        logic [VALUE_W-1:0]   txt [TXT_BUF_LEN];
        pick = $urandom_range(0, 99);
        if (pick < 5)
            len = '0;
        else if (pick < 70)
            len = LEN_REG_W'($urandom_range(1, 6));
        else if (pick < 93)
            len = LEN_REG_W'($urandom_range(7, DEF_PATTERN_MAX - 1));
        else if (pick < 97)
            len = LEN_REG_W'(DEF_PATTERN_MAX);
        else
            len = '1;  // over the store depth, clamps to full depth
        eff  = (len > DEF_PATTERN_MAX) ? DEF_PATTERN_MAX : len;
        nsym = $urandom_range(2, 4);  // small alphabet so partial matches are common
        for (i = 0; i < 4; i++)
            sym[i] = $urandom;
        write_len(len);
        for (i = 0; i < eff; i++)
        begin
            pat[i] = sym[$urandom_range(0, nsym - 1)];
            put_pattern(i, pat[i]);
        end
        if (eff < DEF_PATTERN_MAX && $urandom_range(0, 2) == 0)
        begin
            j = $urandom_range(1, 3);
            for (i = 0; i < j; i++)
                put_pattern($urandom_range(eff, DEF_PATTERN_MAX - 1), $urandom);
        end
        nseq = $urandom_range(1, 4);
        for (s = 0; s < nseq; s++)
        begin
            if ($urandom_range(0, 4) == 0)
                tlen = $urandom_range(1, 2 * eff + 8);
            else
                tlen = $urandom_range(1, eff + 6);
            for (i = 0; i < tlen; i++)
                txt[i] = ($urandom_range(0, 9) == 0) ? $urandom
                                                     : sym[$urandom_range(0, nsym - 1)];
            pick = $urandom_range(0, 9);
            if (eff > 0 && tlen >= eff && pick < 8)
            begin
                at = $urandom_range(0, tlen - eff);
                for (i = 0; i < eff; i++)
                    txt[at + i] = pat[i];
                // near miss: one word of the planted copy is spoiled
                if (pick >= 6)
                begin
                    j = $urandom_range(0, eff - 1);
                    txt[at + j] = ~pat[j];
                end
            end
            for (i = 0; i < tlen; i++)
            begin
                if (eff < DEF_PATTERN_MAX && $urandom_range(0, 39) == 0)
                    put_pattern($urandom_range(eff, DEF_PATTERN_MAX - 1), $urandom);
                else if (eff > 0 && $urandom_range(0, 199) == 0)
                    put_pattern($urandom_range(0, eff - 1), sym[$urandom_range(0, nsym - 1)]);
                put_text(txt[i], i == tlen - 1);
            end
        end
    endtask

    initial
    begin
        int first_random;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        action   <= ACT_TEXT;
        index    <= '0;
        value    <= '0;
        last     <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_cases();
        pressure_case();
        first_random = words_sent;
        while (words_sent - first_random < RANDOM_WORDS)
            random_phase();
        settle();
        $display("covered %0d input words, %0d results checked; empty, clamped, full-depth",
                 words_sent, checked);
        $display("and random patterns with near misses, plus a %0d-cycle result hold-off",
                 HOLD_CYCLES);
        if (errors == 0)
            $display("first_sublist_match_tb: done, clean");
        else
            $display("first_sublist_match_tb: done, errors");
        $finish;
    end

endmodule
